[design/char_deque_with_search_unit_macros.svh]
// Assertion macros shared by the deque RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef CHAR_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH
`define CHAR_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CDQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/cdq_pkg.sv]
// Shared types and constants of the byte deque with search.
// No dependencies; used by the interfaces and every module.
package cdq_pkg;

  // Operation codes on the request channel
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  // Status codes on the response channel
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Entries in the command queue between front and back
  localparam int unsigned CmdQueueDepth = 2;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_FIND,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       found;
    logic [3:0] position;
    logic [4:0] occupancy;
    logic [1:0] status;
  } rsp_t;

endpackage

[design/cdq_if.sv]
// Request and response channel interfaces of the byte deque.
// Depends on cdq_pkg.
interface cdq_req_if;
  import cdq_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] byte_in;

  modport source (output valid, operation, byte_in, input ready);
  modport sink (input valid, operation, byte_in, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       found;
  logic [3:0] position;
  logic [4:0] occupancy;
  logic [1:0] status;

  modport source (output valid, byte_out, found, position, occupancy, status, input ready);
  modport sink (input valid, byte_out, found, position, occupancy, status, output ready);
endinterface

[design/cdq_fifo.sv]
// Short command queue between the decode front and the execution back.
// Depends on cdq_pkg.
module cdq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  cdq_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output cdq_pkg::cmd_t pop_data_o
);
  import cdq_pkg::*;

  localparam int unsigned PW   = (CmdQueueDepth > 1) ? $clog2(CmdQueueDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdQueueDepth + 1);

  cmd_t            slot_q [CmdQueueDepth];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            push, pop;

  assign push_ready_o = (fill_q != CntW'(CmdQueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CmdQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CmdQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    fill_d = fill_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/cdq_front.sv]
// Request front end: accepts transactions and classifies the operation code.
// Depends on cdq_pkg and cdq_req_if.
module cdq_front (
  cdq_req_if.sink       req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output cdq_pkg::cmd_t cmd_o
);
  import cdq_pkg::*;

  assign req_i.ready = cmd_ready_i;
  assign cmd_valid_o = req_i.valid;

  // Map spare operation codes onto a no-op
  always_comb begin
    cmd_o.data = req_i.byte_in;
    unique case (req_i.operation)
      OP_PUSH_FRONT: cmd_o.kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  cmd_o.kind = CMD_PUSH_BACK;
      OP_POP_FRONT:  cmd_o.kind = CMD_POP_FRONT;
      OP_POP_BACK:   cmd_o.kind = CMD_POP_BACK;
      OP_FIND:       cmd_o.kind = CMD_FIND;
      OP_CLEAR:      cmd_o.kind = CMD_CLEAR;
      default:       cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

[design/cdq_back.sv]
// Execution back end: ring store, front slot, count, search sequencer and
// the response register. Depends on cdq_pkg, cdq_rsp_if and the macros header.
`include "char_deque_with_search_unit_macros.svh"

module cdq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cdq_pkg::cmd_t cmd_i,
  cdq_rsp_if.source     rsp_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_DATA,
    S_FIND_ISSUE,
    S_FIND_CHECK,
    S_FIND_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] scan_slot_q, scan_slot_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic [7:0]    key_q, key_d;
  logic          hit_q, hit_d;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic [7:0]    store_q [DEPTH];
  logic [7:0]    rdata_q;
  logic          mem_rd, mem_wr;
  logic [AW-1:0] rd_addr, wr_addr;

  logic          out_free, full, empty, reply;
  logic [AW-1:0] back_slot, last_slot;
  logic [SW-1:0] back_sum, last_sum;
  logic [CW+4:0] occ_ext;
  logic [CW+3:0] pos_ext;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);

  // Slot past the last entry and slot of the last entry, wrapped
  assign back_sum  = SW'(front_q) + SW'(count_q);
  assign last_sum  = SW'(front_q) + SW'(count_q) - SW'(1);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    scan_slot_d = scan_slot_q;
    scan_idx_d  = scan_idx_q;
    key_d       = key_q;
    hit_d       = hit_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    cmd_ready_o = 1'b0;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;
    rd_addr     = front_q;
    wr_addr     = back_slot;
    reply       = 1'b0;
    occ_ext     = '0;
    pos_ext     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          rsp_d       = '0;
          unique case (cmd_i.kind)
            CMD_PUSH_FRONT: begin
              reply = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                front_d = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
                wr_addr = front_d;
                mem_wr  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_PUSH_BACK: begin
              reply = 1'b1;
              if (full) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_wr  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                reply        = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                mem_rd  = 1'b1;
                front_d = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
                count_d = count_q - 1'b1;
                state_d = S_POP_DATA;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                reply        = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                mem_rd  = 1'b1;
                rd_addr = last_slot;
                count_d = count_q - 1'b1;
                state_d = S_POP_DATA;
              end
            end
            CMD_FIND: begin
              key_d       = cmd_i.data;
              hit_d       = 1'b0;
              scan_idx_d  = '0;
              scan_slot_d = front_q;
              state_d     = S_FIND_ISSUE;
            end
            CMD_CLEAR: begin
              reply   = 1'b1;
              front_d = '0;
              count_d = '0;
            end
            CMD_NOP: begin
              reply = 1'b1;
            end
          endcase
        end
      end
      S_POP_DATA: begin
        if (out_free) begin
          reply          = 1'b1;
          rsp_d          = '0;
          rsp_d.byte_out = rdata_q;
          state_d        = S_IDLE;
        end
      end
      S_FIND_ISSUE: begin
        if (scan_idx_q == count_q) begin
          state_d = S_FIND_DONE;
        end else begin
          mem_rd  = 1'b1;
          rd_addr = scan_slot_q;
          state_d = S_FIND_CHECK;
        end
      end
      S_FIND_CHECK: begin
        if (rdata_q == key_q) begin
          hit_d   = 1'b1;
          state_d = S_FIND_DONE;
        end else begin
          scan_idx_d  = scan_idx_q + 1'b1;
          scan_slot_d = (scan_slot_q == AW'(DEPTH - 1)) ? '0 : scan_slot_q + 1'b1;
          state_d     = S_FIND_ISSUE;
        end
      end
      S_FIND_DONE: begin
        if (out_free) begin
          reply       = 1'b1;
          pos_ext     = {4'b0, scan_idx_q};
          rsp_d       = '0;
          rsp_d.found = hit_q;
          // Position field keeps the low bits of the match index
          rsp_d.position = hit_q ? pos_ext[3:0] : 4'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (reply) begin
      occ_ext         = {5'b0, count_d};
      rsp_valid_d     = 1'b1;
      rsp_d.occupancy = occ_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      scan_slot_q <= '0;
      scan_idx_q  <= '0;
      key_q       <= '0;
      hit_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      scan_slot_q <= scan_slot_d;
      scan_idx_q  <= scan_idx_d;
      key_q       <= key_d;
      hit_q       <= hit_d;
      rsp_valid_q <= rsp_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      store_q[wr_addr] <= cmd_i.data;
    end
    if (mem_rd) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.byte_out  = rsp_q.byte_out;
  assign rsp_o.found     = rsp_q.found;
  assign rsp_o.position  = rsp_q.position;
  assign rsp_o.occupancy = rsp_q.occupancy;
  assign rsp_o.status    = rsp_q.status;

  `CDQ_NEVER(a_count_bound, count_q > CW'(DEPTH), "count exceeds capacity")
  `CDQ_NEVER(a_mem_port_excl, mem_rd && mem_wr, "store read and write in one cycle")
  `CDQ_ASSERT(a_scan_in_range, state_q == S_FIND_CHECK |-> scan_idx_q < count_q, "scan past the last entry")
  `CDQ_ASSERT(a_issue_to_check, mem_rd && state_q == S_FIND_ISSUE |=> state_q == S_FIND_CHECK, "find read without compare")

endmodule

[design/char_deque_with_search_unit.sv]
// Top level of the byte deque with search: front end, command queue, back end.
// Depends on cdq_pkg, cdq_if, cdq_front, cdq_fifo and cdq_back.
//
//   Channel   Dir  Modport              Payload
//   req_i     in   cdq_req_if.sink      operation[2:0], byte_in[7:0]
//   rsp_o     out  cdq_rsp_if.source    byte_out, found, position, occupancy, status
//
// A transaction accepted on req_i passes the command queue registers before the back end.
// Push, clear, spare codes and a pop on an empty store are answered from the idle state;
// a pop of a stored byte first reads the store, then answers with the registered read data.
// A find reads and compares the entries one at a time from the front, since the ring
// store has a single read port; a miss ends after one more check of the entry index.
// Reset clears front slot, count, queue and response register; the store
// needs no clearing since only written entries are ever read.
// A stalled rsp_o holds the back end; the two-entry queue still takes requests.
module char_deque_with_search_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_req_if.sink   req_i,
  cdq_rsp_if.source rsp_o
);
  import cdq_pkg::*;

  // Decoded commands from the front end into the queue
  logic front_valid, front_ready;
  cmd_t front_cmd;

  // Queue output into the back end
  logic back_valid, back_ready;
  cmd_t back_cmd;

  // Classify the operation code; hold req_i while the queue is full
  cdq_front u_front (
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // Decouple accept from execution so a long search does not stall req_i at once
  cdq_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  // Execute one command at a time against the ring store and drive rsp_o
  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

[test/deque_checker.sv]
// Checker for the byte deque: watches the request and response channels, predicts each response.
// Depends on cdq_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module deque_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  logic [2:0] req_operation_i,
  input  logic [7:0] req_byte_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  logic [7:0] rsp_byte_out_i,
  input  logic       rsp_found_i,
  input  logic [3:0] rsp_position_i,
  input  logic [4:0] rsp_occupancy_i,
  input  logic [1:0] rsp_status_i,
  output int         mismatches_o,
  output int         pending_o
);
  import cdq_pkg::*;

  // Shadow deque: ring of bytes, index of the front entry, number of entries
  logic [7:0]  ring_bytes [DEPTH];
  int unsigned head_slot  = 0;
  int unsigned fill_level = 0;

  rsp_t awaited_rsp_q [$];
  int   fail_count = 0;

  // Apply one operation to the shadow deque and return the response it owes.
  function automatic rsp_t deque_outcome(input logic [2:0] op, input logic [7:0] data);
    rsp_t        r;
    int unsigned i;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring_bytes[head_slot] = data;
          fill_level++;
        end
      end
      OP_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_bytes[(head_slot + fill_level) % DEPTH] = data;
          fill_level++;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.byte_out = ring_bytes[head_slot];
          head_slot  = (head_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.byte_out = ring_bytes[(head_slot + fill_level - 1) % DEPTH];
          fill_level--;
        end
      end
      OP_FIND: begin
        // first match from the front wins; position keeps the low four bits
        for (i = 0; i < fill_level; i++) begin
          if (!hit && ring_bytes[(head_slot + i) % DEPTH] == data) begin
            hit        = 1'b1;
            r.found    = 1'b1;
            r.position = i[3:0];
          end
        end
      end
      OP_CLEAR: begin
        head_slot  = 0;
        fill_level = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = fill_level[4:0];
    return r;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("deque_checker: %s at %0t", msg, $realtime);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        awaited_rsp_q.push_back(deque_outcome(req_operation_i, req_byte_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp_q.size() == 0) begin
          flag("response with nothing outstanding");
        end else begin
          want = awaited_rsp_q.pop_front();
          if (rsp_byte_out_i !== want.byte_out) begin
            flag($sformatf("byte_out expected %0d got %0d", want.byte_out, rsp_byte_out_i));
          end
          if (rsp_found_i !== want.found) begin
            flag($sformatf("found expected %0d got %0d", want.found, rsp_found_i));
          end
          if (rsp_position_i !== want.position) begin
            flag($sformatf("position expected %0d got %0d", want.position, rsp_position_i));
          end
          if (rsp_occupancy_i !== want.occupancy) begin
            flag($sformatf("occupancy expected %0d got %0d", want.occupancy,
                           rsp_occupancy_i));
          end
          if (rsp_status_i !== want.status) begin
            flag($sformatf("status expected %0d got %0d", want.status, rsp_status_i));
          end
        end
      end
    end
    mismatches_o <= fail_count;
    pending_o    <= awaited_rsp_q.size();
  end

endmodule

[test/testbench.sv]
// Top of the deque testbench: clock, reset, request stimulus, response back-pressure, verdict.
// Depends on cdq_pkg, cdq_if, char_deque_with_search_unit and deque_checker.
`timescale 1ns / 100ps

module testbench;
  import cdq_pkg::*;

  localparam int unsigned DEPTH = 16;

  // The block treats codes six and seven as no-ops
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS_PER_PHASE = 188;
  // A full-store find is the slowest command; leave slack on top
  localparam int DRAIN_CYCLES = 60;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       req_valid = 1'b0;
  logic [2:0] req_op    = OP_PUSH_FRONT;
  logic [7:0] req_byte  = 8'h00;
  logic       rsp_ready = 1'b0;

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatches;
  int outstanding;

  cdq_req_if req_if ();
  cdq_rsp_if rsp_if ();

  assign req_if.valid     = req_valid;
  assign req_if.operation = req_op;
  assign req_if.byte_in   = req_byte;
  assign rsp_if.ready     = rsp_ready;

  char_deque_with_search_unit #(
    .DEPTH (DEPTH)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  deque_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_valid_i     (req_if.valid),
    .req_ready_i     (req_if.ready),
    .req_operation_i (req_if.operation),
    .req_byte_i      (req_if.byte_in),
    .rsp_valid_i     (rsp_if.valid),
    .rsp_ready_i     (rsp_if.ready),
    .rsp_byte_out_i  (rsp_if.byte_out),
    .rsp_found_i     (rsp_if.found),
    .rsp_position_i  (rsp_if.position),
    .rsp_occupancy_i (rsp_if.occupancy),
    .rsp_status_i    (rsp_if.status),
    .mismatches_o    (mismatches),
    .pending_o       (outstanding)
  );

  // 20 ns period
  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  // Throttle the response side: drop ready in receiver_stall_pct cycles of a hundred
  always @(posedge clk) begin
    if (rst_n) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Offer one transaction on the request channel and hold it until accepted.
  // Valid stays high across back-to-back transactions; idle cycles drop it and
  // scramble the payload so an ignored item cannot leak into the deque.
  task automatic send_request(input logic [2:0] op, input logic [7:0] data);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      req_op    <= 3'($urandom);
      req_byte  <= 8'($urandom);
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_byte  <= data;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Random operations. The push/pop balance drifts every 24 items so the
  // occupancy swings between empty and full; most bytes come from a small
  // alphabet so that finds hit at many depths.
  task automatic run_random_ops(input int count);
    int         push_bias;
    int         roll;
    logic [2:0] op;
    logic [7:0] data;
    push_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 85;
          1:       push_bias = 20;
          default: push_bias = 55;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else if (roll < 7) begin
        op = OP_CLEAR;
      end else if (roll < 25) begin
        op = OP_FIND;
      end else if ($urandom_range(0, 99) < push_bias) begin
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      data = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      send_request(op, data);
    end
  endtask

  initial begin
    // Hold reset, then release it on a rising edge
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling.
    // Pops and a find on the empty deque, then the spare codes.
    send_request(OP_POP_FRONT, 8'h5A);
    send_request(OP_POP_BACK, 8'hA5);
    send_request(OP_FIND, 8'h00);
    send_request(OP_SPARE_LO, 8'hFF);
    send_request(OP_SPARE_HI, 8'h00);
    // Push at the front of an empty ring so the front wraps, then fill from the back
    send_request(OP_PUSH_FRONT, 8'hFF);
    for (int k = 1; k < DEPTH; k++) begin
      send_request(OP_PUSH_BACK, 8'(k));
    end
    // Both pushes on a full deque are refused
    send_request(OP_PUSH_BACK, 8'hAA);
    send_request(OP_PUSH_FRONT, 8'h55);
    // Match at the last position, then a miss on a full deque
    send_request(OP_FIND, 8'h0F);
    send_request(OP_FIND, 8'h42);
    send_request(OP_POP_BACK, 8'h00);
    send_request(OP_POP_FRONT, 8'h00);
    send_request(OP_CLEAR, 8'h00);

    // Random part in four flow-control phases
    run_random_ops(RANDOM_OPS_PER_PHASE);

    sender_idle_pct = 84;
    run_random_ops(RANDOM_OPS_PER_PHASE);

    sender_idle_pct = 0;
    receiver_stall_pct <= 84;
    run_random_ops(RANDOM_OPS_PER_PHASE);

    sender_idle_pct = 17;
    receiver_stall_pct <= 17;
    run_random_ops(RANDOM_OPS_PER_PHASE);

    // Drop valid, release back-pressure and drain the outstanding responses.
    // Step the clock first: the checker's count is registered and lags the last acceptance.
    req_valid <= 1'b0;
    receiver_stall_pct <= 0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog: 20 ms, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

[char_deque_with_search_unit.f]
+incdir+design
design/cdq_pkg.sv
design/cdq_if.sv
design/cdq_fifo.sv
design/cdq_front.sv
design/cdq_back.sv
design/char_deque_with_search_unit.sv
test/deque_checker.sv
test/testbench.sv
